@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lcs_pkg
// Types and codes shared by the linear congruence solver.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int unsigned DefWidth = 32;

  localparam logic [1:0] ST_SOLVED = 2'd0;
  localparam logic [1:0] ST_NOSOL  = 2'd1;
  localparam logic [1:0] ST_BADOFF = 2'd2;

  // Divider control: start and its results back.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

@@ rtl/lcs_divider.sv @@
// ----------------------------------------------------------------------------
// lcs_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcs_divider #(
  parameter int unsigned WIDTH = lcs_pkg::DefWidth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcs_pkg::div_ctl_t    ctl,
  input  logic [WIDTH-1:0]     dividend,
  input  logic [WIDTH-1:0]     divisor,
  output lcs_pkg::div_sts_t    sts,
  output logic [WIDTH-1:0]     quotient,
  output logic [WIDTH-1:0]     remainder
);
  import lcs_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[WIDTH-1]};
    diff     = trial - {1'b0, d_r};
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[WIDTH]) begin
        rem_nxt = diff[WIDTH-1:0];
        q_nxt   = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WIDTH-1:0];
        q_nxt   = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

@@ rtl/lcs_mulmod.sv @@
// ----------------------------------------------------------------------------
// lcs_mulmod
// Shift-and-add modular product a*b mod m, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lcs_mulmod #(
  parameter int unsigned WIDTH = lcs_pkg::DefWidth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcs_pkg::div_ctl_t    ctl,
  input  logic [WIDTH-1:0]     op_a,
  input  logic [WIDTH-1:0]     op_b,
  input  logic [WIDTH-1:0]     modulus,
  output lcs_pkg::div_sts_t    sts,
  output logic [WIDTH-1:0]     product
);
  import lcs_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   sum;

  // Operands are already below the modulus, so one subtract reduces.
  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= {1'b0, m_r}) ? WIDTH'(dbl - {1'b0, m_r}) : dbl[WIDTH-1:0];
    sum      = {1'b0, dbl_red} + {1'b0, a_r};
    if (ctl.start) begin
      acc_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      m_nxt    = modulus;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[WIDTH-1]) begin
        acc_nxt = (sum >= {1'b0, m_r}) ? WIDTH'(sum - {1'b0, m_r}) : sum[WIDTH-1:0];
      end else begin
        acc_nxt = dbl_red;
      end
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

@@ rtl/linear_congruence_solver_unit.sv @@
// ----------------------------------------------------------------------------
// linear_congruence_solver_unit
// Least b with s + b*k = 0 mod n, by gcd and extended Euclid.
// ----------------------------------------------------------------------------
// Usage: present modulus, offset and step on the in_ channel as one word.
// The block takes one word at a time; in_tready is low while it works.
// Flow: range check, Euclid on (n, k) for the gcd, a check that the gcd
// divides s, three divisions by the gcd, extended Euclid on (k', n') for the
// inverse, then a modular product. Every quotient comes from one shared
// restoring divider, the product from a shift-and-add unit. A gcd round
// starts the divider and waits for its done; an inverse round divides, then
// registers the product q*|v|, then does the update. An offset not below the
// modulus goes from S_IDLE straight to S_OUT with no arithmetic.
// The result is held in an output register until out_tready takes it; the
// next word is accepted while it waits, and a finished answer stalls only if
// the output register is still full.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_congruence_solver_unit #(
  parameter int unsigned WIDTH = lcs_pkg::DefWidth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // modulus [31:0], offset [63:32], step [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status [1:0], step_count [33:2], zeros above
);
  import lcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_G_DIV, S_G_WAIT, S_CHK, S_RED_N, S_RED_S, S_RED_K,
    S_KMOD, S_E_DIV, S_E_WAIT, S_E_MUL, S_E_SUB, S_FIX, S_MUL, S_MUL_WAIT, S_OUT
  } state_t;

  localparam int unsigned DW = WIDTH + 2; // signed Bezout coefficient width

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] n_r, n_nxt, s_r, s_nxt, k_r, k_nxt;
  logic [WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [DW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] vm_r, vm_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [1:0]       ost_r, ost_nxt;
  logic [WIDTH-1:0] ob_r, ob_nxt;
  logic             ov_r, ov_nxt;

  div_ctl_t         dctl, mctl;
  div_sts_t         dsts, msts;
  logic [WIDTH-1:0] d_a, d_b, d_q, d_rm;
  logic [WIDTH-1:0] m_a, m_b, m_m, m_p;
  logic signed [DW-1:0] pv;
  logic signed [DW-1:0] umod;

  lcs_divider #(.WIDTH(WIDTH)) u_div (
    .clk, .rst_n, .ctl(dctl), .dividend(d_a), .divisor(d_b),
    .sts(dsts), .quotient(d_q), .remainder(d_rm)
  );

  lcs_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk, .rst_n, .ctl(mctl), .op_a(m_a), .op_b(m_b), .modulus(m_m),
    .sts(msts), .product(m_p)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {{(40 - 2 - 32){1'b0}}, 32'(ob_r), ost_r};

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; s_nxt = s_r; k_nxt = k_r;
    x_nxt = x_r; y_nxt = y_r; u_nxt = u_r; v_nxt = v_r;
    q_nxt = q_r; vm_nxt = vm_r; p_nxt = p_r;
    st_nxt = st_r; b_nxt = b_r; ov_nxt = ov_r;
    ost_nxt = ost_r; ob_nxt = ob_r;
    dctl.start = 1'b0;
    mctl.start = 1'b0;
    d_a = x_r;
    d_b = y_r;
    m_a = s_r;
    m_b = x_r;
    m_m = n_r;
    pv   = signed'({2'b00, p_r});
    umod = u_r + DW'(signed'({1'b0, n_r}));
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          n_nxt = in_tdata[WIDTH-1:0];
          s_nxt = in_tdata[32 +: WIDTH];
          k_nxt = in_tdata[64 +: WIDTH];
          x_nxt = in_tdata[WIDTH-1:0];
          y_nxt = in_tdata[64 +: WIDTH];
          if (in_tdata[32 +: WIDTH] >= in_tdata[WIDTH-1:0]) begin
            st_nxt = ST_BADOFF; b_nxt = '0; state_nxt = S_OUT;
          end else begin
            state_nxt = S_G_DIV;
          end
        end
      end
      // Euclid for the gcd: x holds it when y reaches zero.
      S_G_DIV: begin
        if (y_r == '0) begin
          state_nxt = S_CHK;
          dctl.start = 1'b1; d_a = s_r; d_b = x_r;
        end else begin
          dctl.start = 1'b1; state_nxt = S_G_WAIT;
        end
      end
      S_G_WAIT: begin
        if (dsts.done) begin
          x_nxt = y_r; y_nxt = d_rm; state_nxt = S_G_DIV;
        end
      end
      S_CHK: begin
        if (dsts.done) begin
          if (d_rm != '0) begin
            st_nxt = ST_NOSOL; b_nxt = '0; state_nxt = S_OUT;
          end else begin
            dctl.start = 1'b1; d_a = n_r; d_b = x_r; state_nxt = S_RED_N;
          end
        end
      end
      S_RED_N: begin
        if (dsts.done) begin
          n_nxt = d_q;
          dctl.start = 1'b1; d_a = n_r - s_r; d_b = x_r; state_nxt = S_RED_S;
        end
      end
      S_RED_S: begin
        if (dsts.done) begin
          s_nxt = d_q;
          dctl.start = 1'b1; d_a = k_r; d_b = x_r; state_nxt = S_RED_K;
        end
      end
      S_RED_K: begin
        if (dsts.done) begin
          dctl.start = 1'b1; d_a = d_q; d_b = n_r; state_nxt = S_KMOD;
        end
      end
      // k mod n', then reduce s mod n' by reusing s' < n' except n' = s'.
      S_KMOD: begin
        if (dsts.done) begin
          x_nxt = d_rm; y_nxt = n_r;
          u_nxt = DW'(1); v_nxt = '0;
          if (s_r == n_r) s_nxt = '0;
          state_nxt = S_E_DIV;
        end
      end
      // Keep |v| aside while the divider runs; it feeds the product later.
      S_E_DIV: begin
        if (y_r == '0) begin
          state_nxt = S_FIX;
        end else begin
          vm_nxt = v_r[DW-1] ? WIDTH'(-v_r) : v_r[WIDTH-1:0];
          dctl.start = 1'b1; state_nxt = S_E_WAIT;
        end
      end
      S_E_WAIT: begin
        if (dsts.done) begin
          q_nxt = d_q; x_nxt = y_r; y_nxt = d_rm; state_nxt = S_E_MUL;
        end
      end
      // q*|v| never exceeds the modulus, so WIDTH bits hold it.
      S_E_MUL: begin
        p_nxt = q_r * vm_r; state_nxt = S_E_SUB;
      end
      S_E_SUB: begin
        u_nxt = v_r;
        v_nxt = v_r[DW-1] ? u_r + pv : u_r - pv;
        state_nxt = S_E_DIV;
      end
      S_FIX: begin
        if (n_r == WIDTH'(1)) begin
          st_nxt = ST_SOLVED; b_nxt = '0; state_nxt = S_OUT;
        end else begin
          if (u_r < 0) u_nxt = umod;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mctl.start = 1'b1; m_b = u_r[WIDTH-1:0]; state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        m_b = u_r[WIDTH-1:0];
        if (msts.done) begin
          st_nxt = ST_SOLVED; b_nxt = m_p; state_nxt = S_OUT;
        end
      end
      // Hand the answer to the output register once it is free.
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; ost_nxt = st_r; ob_nxt = b_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    n_r <= n_nxt; s_r <= s_nxt; k_r <= k_nxt;
    x_r <= x_nxt; y_r <= y_nxt; u_r <= u_nxt; v_r <= v_nxt;
    q_r <= q_nxt; vm_r <= vm_nxt; p_r <= p_nxt;
    st_r <= st_nxt; b_r <= b_nxt;
    ost_r <= ost_nxt; ob_r <= ob_nxt;
  end

  `ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_r != S_IDLE, !in_tready,
    "input taken while busy")
  `ASSERT_IMPL(a_zero_unsolved, clk, rst_n, ov_r && ost_r != ST_SOLVED, ob_r == '0,
    "non-zero count without solution")
  `ASSERT_NEXT(a_hold_out, clk, rst_n, ov_r && !out_tready,
    ov_r && $stable(ob_r) && $stable(ost_r), "result dropped under stall")

endmodule

@@ tb/lcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_checker
// Watches both channels of the congruence solver, predicts each answer from
// the accepted word and compares it field by field with the returned word.
// ----------------------------------------------------------------------------
module lcs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,   // modulus [31:0], offset [63:32], step [95:64]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // status [1:0], step_count [33:2], zeros above
  output int          fail_count,
  output int          pending
);
  import lcs_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] step_count;
  } answer_t;

  answer_t answers_due[$];

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m);
    longint x, y, u, v, q, tx, tu, r;
    x = a; y = m; u = 1; v = 0;
    while (y != 0) begin
      q = x / y;
      tx = x - q * y;
      tu = u - q * v;
      x = y; y = tx;
      u = v; v = tu;
    end
    r = u % longint'(m);
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic answer_t solve_congruence(logic [31:0] n, logic [31:0] s, logic [31:0] k);
    answer_t a;
    longint unsigned g, nn, ss, kk, b;
    a.step_count = '0;
    if (s >= n) begin
      a.status = ST_BADOFF;
      return a;
    end
    g = gcd64(n, k);
    if (s % g != 0) begin
      a.status = ST_NOSOL;
      return a;
    end
    nn = n / g;
    ss = (64'(n) - s) / g;
    kk = k / g;
    b = ((ss % nn) * inverse_mod(kk % nn, nn)) % nn;
    a.status = ST_SOLVED;
    a.step_count = b[31:0];
    return a;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = answers_due.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        answers_due.push_back(solve_congruence(in_tdata[31:0], in_tdata[63:32],
                                               in_tdata[95:64]));
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result word with no answer due");
        end else begin
          want = answers_due.pop_front();
          if (out_tdata[1:0] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tdata[1:0], want.status));
          if (out_tdata[33:2] !== want.step_count)
            report_mismatch($sformatf("step_count %0d, want %0d", out_tdata[33:2],
                                      want.step_count));
          if (out_tdata[39:34] !== '0)
            report_mismatch("padding bits not zero");
        end
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives congruence problems into the solver with random gaps and stalls;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  localparam int RANDOM_WORDS = 300;
  localparam int QUIET_LIMIT  = 60000;   // watchdog limit, above the slowest answer and the early hold-off

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // modulus [31:0], offset [63:32], step [95:64]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // status [1:0], step_count [33:2], zeros above
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;     // no idling in the closing stretch
  int          quiet = 0;

  always #1 clk = ~clk;

  linear_congruence_solver_unit dut (.*);

  lcs_checker checker_i (.*);

  // Push one word and hold it until the block takes it; valid stays high
  // into the next word unless a gap drops it.
  task automatic send_word(logic [31:0] n, logic [31:0] s, logic [31:0] k);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {k, s, n};
    do @(posedge clk); while (!in_tready);
  endtask

  // Random operands: mostly small or structured, sometimes full width.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(1, 30);
      1: return $urandom_range(1, 5000);
      2: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Receiver: random stalls, one long hold-off early on to fill the block.
  initial begin
    int hold;
    @(posedge rst_n);
    out_tready <= 1'b0;
    repeat (8000) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 19);
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] n, s, k, g;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes and the named special cases.
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);        // offset equal to modulus
    send_word(32'd5, 32'hFFFF_FFFF, 32'd3);                // offset above modulus
    send_word(32'd0, 32'd0, 32'd7);                        // zero modulus
    send_word(32'd1, 32'd0, 32'd9);                        // modulus one
    send_word(32'd1, 32'd1, 32'd9);
    send_word(32'd10, 32'd0, 32'd0);                       // step zero
    send_word(32'd10, 32'd4, 32'd0);
    send_word(32'd12, 32'd0, 32'd5);                       // offset zero
    send_word(32'd12, 32'd3, 32'd4);                       // no solution
    send_word(32'd12, 32'd4, 32'd6);                       // shared factor, no solution
    send_word(32'd12, 32'd6, 32'd12);                      // gcd equals modulus, no solution
    send_word(32'd10, 32'd4, 32'd6);                       // shared factor, solvable
    send_word(32'hFFFF_FFFB, 32'd1, 32'hFFFF_FFFA);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(32'hB520_0000, 32'h4AC0_0000, 32'h0000_0300);
    send_word(32'd2, 32'd1, 32'd1);
    send_word(32'd2971215073, 32'd1836311903, 32'd1836311903); // long Euclid chain
    // Random: mostly in-range problems, some solvable by construction.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 40) calm = 1'b1;
      n = pick_value();
      if (n < 2) n = 2;
      k = pick_value();
      case ($urandom_range(0, 9))
        0: s = $urandom;                                   // often out of range
        1, 2: begin
          g = gcd_of(n, k);
          s = g * $urandom_range(0, (n - 1) / g);          // solvable
        end
        default: s = $urandom % n;
      endcase
      if ($urandom_range(0, 30) == 0) k = 0;
      send_word(n, s, k);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_divider.sv
rtl/lcs_mulmod.sv
rtl/linear_congruence_solver_unit.sv
tb/lcs_checker.sv
tb/testbench.sv
